FILE: hdl/match_timer_bank_assert.svh
// Assertion macros shared by the timer bank modules.
`ifndef MATCH_TIMER_BANK_ASSERT_SVH
`define MATCH_TIMER_BANK_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MTB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MTB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mtb_pkg.sv
package mtb_pkg;

  localparam int NUM_TIMERS_DEF  = 4;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int VEC_W           = 4;
  localparam int KIND_W          = 2;
  localparam int UNIT_W          = 2;
  localparam int SEL_W           = 3;
  localparam int ACT_W           = 3;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [SEL_W-1:0] REG_CTRL     = 3'd0;
  localparam logic [SEL_W-1:0] REG_COUNT    = 3'd1;
  localparam logic [SEL_W-1:0] REG_PRESCALE = 3'd2;
  localparam logic [SEL_W-1:0] REG_MATCH    = 3'd3;
  localparam logic [SEL_W-1:0] REG_ACTION   = 3'd4;
  localparam logic [SEL_W-1:0] REG_IRQ      = 3'd5;

  localparam int ACT_IRQ   = 0;
  localparam int ACT_RESET = 1;
  localparam int ACT_STOP  = 2;

  localparam int CTRL_EN   = 0;
  localparam int CTRL_HOLD = 1;

  typedef struct packed {
    logic              go;
    logic              tick;
    logic              write;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] wdata;
  } cmd_t;

endpackage

FILE: hdl/mtb_req_if.sv
interface mtb_req_if;
  import mtb_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [UNIT_W-1:0] unit;
  logic [SEL_W-1:0]  reg_sel;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, kind, unit, reg_sel, wdata, input ready);
  modport sink (input valid, kind, unit, reg_sel, wdata, output ready);
endinterface

FILE: hdl/mtb_rsp_if.sv
interface mtb_rsp_if;
  import mtb_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic [VEC_W-1:0]  irq_vector;

  modport source (output valid, rdata, irq_vector, input ready);
  modport sink (input valid, rdata, irq_vector, output ready);
endinterface

FILE: hdl/match_timer_bank.sv
// Bank of timers, each with a prescaler and a match register.
// req channel: one word per item; kind selects tick, register write or
// register read, unit and reg_sel address the register, wdata is written.
// rsp channel: one word per accepted req word, in order; rdata holds the
// read value (zero for ticks and writes), irq_vector the interrupt flags of
// timers 0 to 3 after the item.
// After req acceptance the req word is registered, the timer update and
// read select run on it, and the result lands in the rsp register. One word
// per cycle is sustained while rsp.ready stays high; the single timer update
// stage between those two registers sets that rate.
// If rsp stalls, the registered req word waits and req.ready drops once
// that register is full; nothing is lost or dropped.
// Reset (rst, synchronous) clears every timer register, all flags and the
// valid bits of both pipeline registers; req.ready is high when it ends.
module match_timer_bank #(
  parameter int NUM_TIMERS  = mtb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = mtb_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  mtb_req_if.sink   req,
  mtb_rsp_if.source rsp
);
  import mtb_pkg::*;

  `include "match_timer_bank_assert.svh"

  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [UNIT_W-1:0] s1_unit;
  logic [SEL_W-1:0]  s1_sel;
  logic [DATA_W-1:0] s1_wdata;
  logic              out_free;
  logic              fire;
  cmd_t              cmd;

  logic [DATA_W-1:0] rd_timer [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] irq_timer;
  logic [DATA_W-1:0] rd_all [VEC_W];
  logic [VEC_W-1:0]  vec_next;
  logic [DATA_W-1:0] rdata_next;

  assign out_free  = !rsp.valid || rsp.ready;
  assign fire      = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_kind  <= req.kind;
      s1_unit  <= req.unit;
      s1_sel   <= req.reg_sel;
      s1_wdata <= req.wdata;
    end
  end

  always_comb begin
    cmd.go    = fire;
    cmd.tick  = (s1_kind == KIND_TICK);
    cmd.write = (s1_kind == KIND_WRITE);
    cmd.sel   = s1_sel;
    cmd.wdata = s1_wdata;
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
    mtb_timer #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .hit      (3'(s1_unit) == 3'(i)),
      .rd_value (rd_timer[i]),
      .irq_next (irq_timer[i])
    );
  end

  for (genvar i = 0; i < VEC_W; i++) begin : g_view
    if (i < NUM_TIMERS) begin : g_on
      assign rd_all[i]   = rd_timer[i];
      assign vec_next[i] = irq_timer[i];
    end else begin : g_off
      assign rd_all[i]   = '0;
      assign vec_next[i] = 1'b0;
    end
  end

  assign rdata_next = (s1_kind == KIND_READ) ? rd_all[s1_unit] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.rdata      <= rdata_next;
      rsp.irq_vector <= vec_next;
    end
  end

  `MTB_ASSERT_IMP(a_rsp_from_fire, $rose(rsp.valid), $past(fire),
                  "rsp word without a processed req word")
  `MTB_ASSERT_NXT(a_s1_holds, s1_valid && !out_free,
                  s1_valid && $stable(s1_wdata) && $stable(s1_kind),
                  "queued req word lost while rsp stalled")
  `MTB_ASSERT_NXT(a_rdata_zero, fire && s1_kind != KIND_READ, rsp.rdata == '0,
                  "nonzero rdata on a word that is not a read")

endmodule

FILE: hdl/mtb_timer.sv
module mtb_timer #(
  parameter int COUNT_WIDTH = mtb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mtb_pkg::cmd_t             cmd,
  input  logic                      hit,
  output logic [mtb_pkg::DATA_W-1:0] rd_value,
  output logic                      irq_next
);
  import mtb_pkg::*;

  `include "match_timer_bank_assert.svh"

  localparam int W = COUNT_WIDTH;

  logic             en, en_next;
  logic             hold, hold_next;
  logic [W-1:0]     count, count_next;
  logic [W-1:0]     pcount, pcount_next;
  logic [W-1:0]     plimit, plimit_next;
  logic [W-1:0]     match, match_next;
  logic [ACT_W-1:0] act, act_next;
  logic             flag, flag_next;
  logic [W-1:0]     stepped;

  assign stepped = (act[ACT_RESET] && (count == match)) ? '0 : count + W'(1);

  always_comb begin
    en_next     = en;
    hold_next   = hold;
    count_next  = count;
    pcount_next = pcount;
    plimit_next = plimit;
    match_next  = match;
    act_next    = act;
    flag_next   = flag;
    if (cmd.go && cmd.tick) begin
      if (hold) begin
        count_next  = '0;
        pcount_next = '0;
      end else if (en) begin
        if (pcount < plimit) begin
          pcount_next = pcount + W'(1);
        end else begin
          pcount_next = '0;
          count_next  = stepped;
          if (stepped == match) begin
            if (act[ACT_IRQ]) flag_next = 1'b1;
            if (act[ACT_STOP]) en_next = 1'b0;
          end
        end
      end
    end else if (cmd.go && cmd.write && hit) begin
      case (cmd.sel)
        REG_CTRL: begin
          en_next   = cmd.wdata[CTRL_EN];
          hold_next = cmd.wdata[CTRL_HOLD];
          if (cmd.wdata[CTRL_HOLD]) begin
            count_next  = '0;
            pcount_next = '0;
          end
        end
        REG_COUNT:    count_next  = cmd.wdata[W-1:0];
        REG_PRESCALE: plimit_next = cmd.wdata[W-1:0];
        REG_MATCH:    match_next  = cmd.wdata[W-1:0];
        REG_ACTION:   act_next    = cmd.wdata[ACT_W-1:0];
        REG_IRQ:      if (cmd.wdata[0]) flag_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en     <= 1'b0;
      hold   <= 1'b0;
      count  <= '0;
      pcount <= '0;
      plimit <= '0;
      match  <= '0;
      act    <= '0;
      flag   <= 1'b0;
    end else begin
      en     <= en_next;
      hold   <= hold_next;
      count  <= count_next;
      pcount <= pcount_next;
      plimit <= plimit_next;
      match  <= match_next;
      act    <= act_next;
      flag   <= flag_next;
    end
  end

  always_comb begin
    case (cmd.sel)
      REG_CTRL:     rd_value = DATA_W'({hold, en});
      REG_COUNT:    rd_value = DATA_W'(count);
      REG_PRESCALE: rd_value = DATA_W'(plimit);
      REG_MATCH:    rd_value = DATA_W'(match);
      REG_ACTION:   rd_value = DATA_W'(act);
      REG_IRQ:      rd_value = DATA_W'(flag);
      default:      rd_value = '0;
    endcase
  end

  assign irq_next = flag_next;

  `MTB_ASSERT_NXT(a_hold_clears, cmd.go && cmd.tick && hold,
                  count == '0 && pcount == '0, "held timer did not clear")
  `MTB_ASSERT_NXT(a_idle_keeps, !cmd.go,
                  $stable(count) && $stable(pcount) && $stable(flag),
                  "timer state moved without a word")
  `MTB_ASSERT_NXT(a_stop_on_match,
                  cmd.go && cmd.tick && !hold && en && !(pcount < plimit) &&
                  act[ACT_STOP] && stepped == match,
                  !en, "stop on match did not clear enable")

endmodule

FILE: tb/timer_bank_checker.sv
module timer_bank_checker (
  input  logic clk,
  input  logic rst,
  mtb_req_if   req,
  mtb_rsp_if   rsp,
  output int   errors,
  output int   waiting
);
  import mtb_pkg::*;

  localparam int NT = NUM_TIMERS_DEF;
  localparam int CW = COUNT_WIDTH_DEF;
  localparam int IRQ_CLEAR_BIT = 0;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [VEC_W-1:0]  irq_vector;
  } rsp_word_t;

  logic             run_en    [NT];
  logic             in_hold   [NT];
  logic [CW-1:0]    cnt       [NT];
  logic [CW-1:0]    pre_cnt   [NT];
  logic [CW-1:0]    pre_lim   [NT];
  logic [CW-1:0]    match_val [NT];
  logic [ACT_W-1:0] action    [NT];
  logic             irq_flag  [NT];

  rsp_word_t expected_q[$];
  int fail_count = 0;
  int word_no = 0;

  assign errors  = fail_count;
  assign waiting = expected_q.size();

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want_v);
    $display("checker: word %0d %s got %h want %h", word_no, what, got, want_v);
    fail_count++;
  endtask

  function automatic rsp_word_t predict_response(input logic [KIND_W-1:0] kind,
                                                 input logic [UNIT_W-1:0] u,
                                                 input logic [SEL_W-1:0]  sel,
                                                 input logic [DATA_W-1:0] wdata);
    rsp_word_t r;
    r.rdata      = '0;
    r.irq_vector = '0;
    case (kind)
      KIND_TICK: begin
        for (int t = 0; t < NT; t++) begin
          if (in_hold[t]) begin
            cnt[t]     = '0;
            pre_cnt[t] = '0;
          end else if (run_en[t]) begin
            if (pre_cnt[t] < pre_lim[t]) begin
              pre_cnt[t] = pre_cnt[t] + 1'b1;
            end else begin
              pre_cnt[t] = '0;
              if (action[t][ACT_RESET] && cnt[t] == match_val[t]) cnt[t] = '0;
              else cnt[t] = cnt[t] + 1'b1;
              if (cnt[t] == match_val[t]) begin
                if (action[t][ACT_IRQ]) irq_flag[t] = 1'b1;
                if (action[t][ACT_STOP]) run_en[t] = 1'b0;
              end
            end
          end
        end
      end
      KIND_WRITE: begin
        if (int'(u) < NT) begin
          case (sel)
            REG_CTRL: begin
              run_en[u]  = wdata[CTRL_EN];
              in_hold[u] = wdata[CTRL_HOLD];
              if (wdata[CTRL_HOLD]) begin
                cnt[u]     = '0;
                pre_cnt[u] = '0;
              end
            end
            REG_COUNT:    cnt[u] = wdata[CW-1:0];
            REG_PRESCALE: pre_lim[u] = wdata[CW-1:0];
            REG_MATCH:    match_val[u] = wdata[CW-1:0];
            REG_ACTION:   action[u] = wdata[ACT_W-1:0];
            REG_IRQ: begin
              if (wdata[IRQ_CLEAR_BIT]) irq_flag[u] = 1'b0;
            end
            default: ;
          endcase
        end
      end
      KIND_READ: begin
        if (int'(u) < NT) begin
          case (sel)
            REG_CTRL: begin
              r.rdata[CTRL_EN]   = run_en[u];
              r.rdata[CTRL_HOLD] = in_hold[u];
            end
            REG_COUNT:    r.rdata = DATA_W'(cnt[u]);
            REG_PRESCALE: r.rdata = DATA_W'(pre_lim[u]);
            REG_MATCH:    r.rdata = DATA_W'(match_val[u]);
            REG_ACTION:   r.rdata = DATA_W'(action[u]);
            REG_IRQ:      r.rdata[IRQ_CLEAR_BIT] = irq_flag[u];
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    for (int t = 0; t < NT && t < VEC_W; t++) r.irq_vector[t] = irq_flag[t];
    return r;
  endfunction

  always @(posedge clk) begin : track
    rsp_word_t want;
    if (rst) begin
      for (int t = 0; t < NT; t++) begin
        run_en[t]    = 1'b0;
        in_hold[t]   = 1'b0;
        cnt[t]       = '0;
        pre_cnt[t]   = '0;
        pre_lim[t]   = '0;
        match_val[t] = '0;
        action[t]    = '0;
        irq_flag[t]  = 1'b0;
      end
      expected_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_q.push_back(predict_response(req.kind, req.unit, req.reg_sel, req.wdata));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("word with nothing pending", rsp.rdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (rsp.rdata !== want.rdata) report_mismatch("rdata", rsp.rdata, want.rdata);
          if (rsp.irq_vector !== want.irq_vector) begin
            report_mismatch("irq_vector", DATA_W'(rsp.irq_vector), DATA_W'(want.irq_vector));
          end
        end
        word_no++;
      end
    end
  end
endmodule

FILE: tb/tb.sv
module tb;
  import mtb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;
  localparam logic [SEL_W-1:0]  REG_SPARE_LO = 3'd6;
  localparam logic [SEL_W-1:0]  REG_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int PRESSURE_AT  = 400;
  localparam int PRESSURE_LEN = 150;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [UNIT_W-1:0] unit;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] wdata;
  } bus_word_t;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   burst_left;

  mtb_req_if req ();
  mtb_rsp_if rsp ();

  match_timer_bank u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  timer_bank_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (failures),
    .waiting (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [UNIT_W-1:0] u,
                           input logic [SEL_W-1:0] s, input logic [DATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid   <= 1'b1;
    req.kind    <= k;
    req.unit    <= u;
    req.reg_sel <= s;
    req.wdata   <= d;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic bus_word_t random_word();
    bus_word_t w;
    int pick;
    pick    = $urandom_range(0, 99);
    w.unit  = UNIT_W'($urandom_range(0, 3));
    w.sel   = SEL_W'($urandom_range(REG_CTRL, REG_IRQ));
    w.wdata = $urandom();
    if (pick < 52) begin
      w.kind = KIND_TICK;
    end else if (pick < 66) begin
      w.kind = KIND_READ;
      if ($urandom_range(0, 9) == 0) begin
        w.sel = ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
      end
    end else if (pick < 97) begin
      w.kind = KIND_WRITE;
      case (w.sel)
        REG_CTRL: begin
          w.wdata[CTRL_EN]   = ($urandom_range(0, 9) != 0);
          w.wdata[CTRL_HOLD] = ($urandom_range(0, 7) == 0);
        end
        REG_COUNT: begin
          case ($urandom_range(0, 3))
            0: w.wdata = $urandom();
            1: w.wdata = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: w.wdata = $urandom_range(0, 12);
          endcase
        end
        REG_PRESCALE: begin
          case ($urandom_range(0, 9))
            0: w.wdata = $urandom();
            1: w.wdata = $urandom_range(4, 20);
            default: w.wdata = $urandom_range(0, 3);
          endcase
        end
        REG_MATCH: begin
          case ($urandom_range(0, 6))
            0: w.wdata = $urandom();
            1: w.wdata = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: w.wdata = $urandom_range(0, 12);
          endcase
        end
        default: ;
      endcase
      if ($urandom_range(0, 15) == 0) begin
        w.sel = ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
      end
    end else begin
      w.kind = KIND_NONE;
    end
    return w;
  endfunction

  initial begin : rsp_side
    int cyc;
    int hold_left;
    int phase;
    rsp.ready = 1'b0;
    cyc       = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (cyc == PRESSURE_AT) hold_left = PRESSURE_LEN;
        phase = (cyc / 50) % 4;
        if (hold_left > 0) begin
          hold_left--;
          rsp.ready <= 1'b0;
        end else if (phase == 0) begin
          rsp.ready <= 1'b1;
        end else if (phase == 1) begin
          rsp.ready <= ($urandom_range(0, 3) != 0);
        end else if (phase == 2) begin
          rsp.ready <= (cyc % 3 != 0);
        end else begin
          rsp.ready <= ($urandom_range(0, 1) != 0);
        end
        cyc++;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    bus_word_t w;
    req.valid   = 1'b0;
    req.kind    = KIND_TICK;
    req.unit    = '0;
    req.reg_sel = REG_CTRL;
    req.wdata   = '0;
    rst         = 1'b1;
    burst_left  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_word(KIND_READ,  2'd0, REG_CTRL,     32'h0);
    send_word(KIND_WRITE, 2'd0, REG_PRESCALE, 32'd1);
    send_word(KIND_WRITE, 2'd0, REG_MATCH,    32'd2);
    send_word(KIND_WRITE, 2'd0, REG_ACTION,   32'hFFFF_FFFB);
    send_word(KIND_WRITE, 2'd0, REG_CTRL,     32'hFFFF_FFFD);
    send_word(KIND_WRITE, 2'd1, REG_COUNT,    32'hFFFF_FFFE);
    send_word(KIND_WRITE, 2'd1, REG_MATCH,    32'h0);
    send_word(KIND_WRITE, 2'd1, REG_ACTION,   32'd5);
    send_word(KIND_WRITE, 2'd1, REG_CTRL,     32'd1);
    send_word(KIND_WRITE, 2'd2, REG_PRESCALE, 32'hFFFF_FFFF);
    send_word(KIND_WRITE, 2'd2, REG_CTRL,     32'd1);
    send_word(KIND_WRITE, 2'd3, REG_CTRL,     32'd3);
    repeat (6) send_word(KIND_TICK, 2'd3, REG_SPARE_HI, 32'hFFFF_FFFF);
    send_word(KIND_WRITE, 2'd2, REG_PRESCALE, 32'h0);
    send_word(KIND_TICK,  2'd0, REG_CTRL,     32'h0);
    send_word(KIND_READ,  2'd0, REG_COUNT,    32'h0);
    send_word(KIND_READ,  2'd1, REG_CTRL,     32'h0);
    send_word(KIND_READ,  2'd2, REG_COUNT,    32'h0);
    send_word(KIND_WRITE, 2'd0, REG_IRQ,      32'hFFFF_FFFF);
    send_word(KIND_READ,  2'd3, REG_SPARE_HI, 32'h0);
    send_word(KIND_NONE,  2'd2, REG_SPARE_LO, 32'h5A5A_A5A5);
    send_word(KIND_WRITE, 2'd1, REG_SPARE_LO, 32'hFFFF_FFFF);

    repeat (RANDOM_WORDS) begin
      w = random_word();
      send_word(w.kind, w.unit, w.sel, w.wdata);
    end
    req.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
